// ===== rtl/eseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq_pkg
// Types, character codes and helper functions shared by the escape decoder.
// ----------------------------------------------------------------------------
package eseq_pkg;

	localparam int CP_W    = 21;  // input code point width
	localparam int CHAR_W  = 32;  // decoded character width
	localparam int DIG_W   = 7;   // stored digit character width
	localparam int DIG_N   = 7;   // digits kept for a failed escape

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_HEX  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_X  = 2'd0,
		KIND_U  = 2'd1,
		KIND_UU = 2'd2
	} kind_t;

	localparam logic [CP_W-1:0] CH_BSL = 21'h5C;
	localparam logic [CP_W-1:0] CH_X   = 21'h78;
	localparam logic [CP_W-1:0] CH_U   = 21'h75;
	localparam logic [CP_W-1:0] CH_UU  = 21'h55;
	localparam logic [CP_W-1:0] CH_0   = 21'h30;
	localparam logic [CP_W-1:0] CH_A   = 21'h61;
	localparam logic [CP_W-1:0] CH_B   = 21'h62;
	localparam logic [CP_W-1:0] CH_F   = 21'h66;
	localparam logic [CP_W-1:0] CH_N   = 21'h6E;
	localparam logic [CP_W-1:0] CH_R   = 21'h72;
	localparam logic [CP_W-1:0] CH_T   = 21'h74;
	localparam logic [CP_W-1:0] CH_V   = 21'h76;

	localparam logic [CHAR_W-1:0] CTL_NUL = 32'd0;
	localparam logic [CHAR_W-1:0] CTL_BEL = 32'd7;
	localparam logic [CHAR_W-1:0] CTL_BS  = 32'd8;
	localparam logic [CHAR_W-1:0] CTL_FF  = 32'd12;
	localparam logic [CHAR_W-1:0] CTL_LF  = 32'd10;
	localparam logic [CHAR_W-1:0] CTL_CR  = 32'd13;
	localparam logic [CHAR_W-1:0] CTL_HT  = 32'd9;
	localparam logic [CHAR_W-1:0] CTL_VT  = 32'd11;

	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} hex_t;

	// one queued item of work: optional failed-escape flush, then optional char
	typedef struct packed {
		logic                          flush;
		kind_t                         kind;
		logic [2:0]                    ndig;
		logic [DIG_N-1:0][DIG_W-1:0]   digits;
		logic                          has_char;
		logic [CHAR_W-1:0]             chr;
		logic                          eos;
	} job_t;

	function automatic hex_t hex_decode(input logic [CP_W-1:0] c);
		hex_t r;
		r.ok = 1'b0;
		r.d  = c[3:0];
		if (c inside {[21'h30:21'h39]}) begin
			r.ok = 1'b1;
		end else if (c inside {[21'h61:21'h66], [21'h41:21'h46]}) begin
			r.ok = 1'b1;
			r.d  = c[3:0] + 4'd9;
		end
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] kind_letter(input kind_t k);
		logic [CHAR_W-1:0] r;
		case (k)
			KIND_X:  r = {11'd0, CH_X};
			KIND_U:  r = {11'd0, CH_U};
			default: r = {11'd0, CH_UU};
		endcase
		return r;
	endfunction

	function automatic logic [3:0] kind_digits(input kind_t k);
		logic [3:0] r;
		case (k)
			KIND_X:  r = 4'd2;
			KIND_U:  r = 4'd4;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/eseq_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq channel interfaces
// Valid/ready channels for input characters and decoded results.
// ----------------------------------------------------------------------------
interface eseq_in_if;
	logic                       valid;
	logic                       ready;
	logic [eseq_pkg::CP_W-1:0]  code_point;
	logic                       end_of_string;

	modport source (output valid, output code_point, output end_of_string, input ready);
	modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

interface eseq_out_if;
	logic                         valid;
	logic                         ready;
	logic [eseq_pkg::CHAR_W-1:0]  decoded_char;
	logic                         string_done;
	logic                         last_of_run;

	modport source (output valid, output decoded_char, output string_done,
		output last_of_run, input ready);
	modport sink   (input valid, input decoded_char, input string_done,
		input last_of_run, output ready);
endinterface

// ===== rtl/escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Backslash escape decoder over a stream of code points, with hex escapes.
// ----------------------------------------------------------------------------
// channel | dir | fields                                     | moves
// text    | in  | code_point[20:0], end_of_string            | one char per item
// result  | out | decoded_char[31:0], string_done, last_of_run | one char per item
//
// the front takes one input item per cycle while the work queue has room
// the back sends one result per cycle while the receiver takes it; a failed hex
// escape gives up to 9 results from one item, the queue takes in further items
// during such a burst and then the input stalls until the back has caught up
// an accepted input item is written into the queue, then into the output register
// reset clears escape state, the queue and the output valid flag at once
// a stalled result holds the back; the front keeps going until the queue fills
module escape_sequence_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	eseq_in_if.sink     text,
	eseq_out_if.source  result
);

	logic            push, pop, q_full, q_not_empty;
	eseq_pkg::job_t  push_job, head;

	eseq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	eseq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	eseq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== rtl/eseq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq_front
// Accepts characters, tracks the escape state and queues the work to emit.
// ----------------------------------------------------------------------------
module eseq_front (
	input  logic               clk,
	input  logic               arst_n,
	eseq_in_if.sink            text,
	input  logic               q_full,
	output logic               push,
	output eseq_pkg::job_t     job
);

	eseq_pkg::mode_t                                     mode_q, mode_n;
	eseq_pkg::kind_t                                     kind_q, kind_n;
	logic [2:0]                                          cnt_q, cnt_n;
	logic [eseq_pkg::CHAR_W-1:0]                         hexv_q, hexv_n;
	logic [eseq_pkg::DIG_W-1:0]                          store_q [eseq_pkg::DIG_N];
	logic [eseq_pkg::DIG_N-1:0][eseq_pkg::DIG_W-1:0]     digits_w;
	logic                                                store_we;
	logic                                                emit;
	logic                                                acc;
	logic [eseq_pkg::CP_W-1:0]                           c;
	logic                                                eos;
	eseq_pkg::hex_t                                      hv;

	assign text.ready = !q_full;
	assign acc        = text.valid && text.ready;
	assign c          = text.code_point;
	assign eos        = text.end_of_string;
	assign hv         = eseq_pkg::hex_decode(c);
	assign push       = acc && emit;

	// buffered digits including the one written by this item
	always_comb begin
		for (int i = 0; i < eseq_pkg::DIG_N; i++) begin
			digits_w[i] = (store_we && cnt_q == 3'(i)) ? c[eseq_pkg::DIG_W-1:0] : store_q[i];
		end
	end

	always_comb begin
		mode_n       = mode_q;
		kind_n       = kind_q;
		cnt_n        = cnt_q;
		hexv_n       = hexv_q;
		store_we     = 1'b0;
		emit         = 1'b0;
		job          = '0;
		job.kind     = kind_q;
		job.ndig     = cnt_q;
		job.digits   = digits_w;
		job.chr      = {11'd0, c};
		job.eos      = eos;
		case (mode_q)
			eseq_pkg::MODE_ESC: begin
				mode_n       = eseq_pkg::MODE_IDLE;
				emit         = 1'b1;
				job.has_char = 1'b1;
				case (c)
					eseq_pkg::CH_0: job.chr = eseq_pkg::CTL_NUL;
					eseq_pkg::CH_A: job.chr = eseq_pkg::CTL_BEL;
					eseq_pkg::CH_B: job.chr = eseq_pkg::CTL_BS;
					eseq_pkg::CH_F: job.chr = eseq_pkg::CTL_FF;
					eseq_pkg::CH_N: job.chr = eseq_pkg::CTL_LF;
					eseq_pkg::CH_R: job.chr = eseq_pkg::CTL_CR;
					eseq_pkg::CH_T: job.chr = eseq_pkg::CTL_HT;
					eseq_pkg::CH_V: job.chr = eseq_pkg::CTL_VT;
					eseq_pkg::CH_X, eseq_pkg::CH_U, eseq_pkg::CH_UU: begin
						// escape letter on the last char stays a literal
						if (!eos) begin
							emit         = 1'b0;
							job.has_char = 1'b0;
							kind_n       = (c == eseq_pkg::CH_X) ? eseq_pkg::KIND_X :
								(c == eseq_pkg::CH_U) ? eseq_pkg::KIND_U : eseq_pkg::KIND_UU;
							cnt_n        = 3'd0;
							hexv_n       = '0;
							mode_n       = eseq_pkg::MODE_HEX;
						end
					end
					default: ;
				endcase
			end
			eseq_pkg::MODE_HEX: begin
				if (!hv.ok) begin
					// failed escape: flush literals, then handle the char fresh
					job.flush = 1'b1;
					emit      = 1'b1;
					mode_n    = eseq_pkg::MODE_IDLE;
					cnt_n     = 3'd0;
					if (c == eseq_pkg::CH_BSL && !eos) begin
						mode_n = eseq_pkg::MODE_ESC;
					end else begin
						job.has_char = 1'b1;
					end
				end else begin
					hexv_n = {hexv_q[eseq_pkg::CHAR_W-5:0], hv.d};
					if ({1'b0, cnt_q} + 4'd1 >= eseq_pkg::kind_digits(kind_q)) begin
						emit         = 1'b1;
						job.has_char = 1'b1;
						job.chr      = hexv_n;
						mode_n       = eseq_pkg::MODE_IDLE;
						cnt_n        = 3'd0;
					end else begin
						store_we = 1'b1;
						cnt_n    = cnt_q + 3'd1;
						if (eos) begin
							emit      = 1'b1;
							job.flush = 1'b1;
							job.ndig  = cnt_q + 3'd1;
						end
					end
				end
			end
			default: begin
				if (c == eseq_pkg::CH_BSL && !eos) begin
					mode_n = eseq_pkg::MODE_ESC;
				end else begin
					emit         = 1'b1;
					job.has_char = 1'b1;
				end
			end
		endcase
		if (eos) begin
			mode_n = eseq_pkg::MODE_IDLE;
			cnt_n  = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= eseq_pkg::MODE_IDLE;
			kind_q <= eseq_pkg::KIND_X;
			cnt_q  <= 3'd0;
		end else if (acc) begin
			mode_q <= mode_n;
			kind_q <= kind_n;
			cnt_q  <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hexv_q <= hexv_n;
		end
		if (acc && store_we) begin
			store_q[cnt_q] <= c[eseq_pkg::DIG_W-1:0];
		end
	end

endmodule

// ===== rtl/eseq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq_queue
// Small register queue of work items between the front and back parts.
// ----------------------------------------------------------------------------
module eseq_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  eseq_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output eseq_pkg::job_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	eseq_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/eseq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq_back
// Walks queued work items, sending their characters one per cycle while ready.
// ----------------------------------------------------------------------------
module eseq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  eseq_pkg::job_t  head,
	output logic            pop,
	eseq_out_if.source      result
);

	logic [3:0]                   idx_q;
	logic                         is_letter, is_digit, last, load;
	logic [2:0]                   dsel;
	logic [eseq_pkg::CHAR_W-1:0]  value;
	logic                         ov_q;
	logic [eseq_pkg::CHAR_W-1:0]  char_q;
	logic                         done_q, last_q;

	// sequence per flush item: letter, digits 1..ndig, then the char if any
	assign is_letter = head.flush && (idx_q == 4'd0);
	assign is_digit  = head.flush && (idx_q != 4'd0) && (idx_q <= {1'b0, head.ndig});
	assign dsel      = idx_q[2:0] - 3'd1;
	assign last      = head.has_char ? !(is_letter || is_digit)
		: (idx_q == {1'b0, head.ndig});

	always_comb begin
		if (is_letter) begin
			value = eseq_pkg::kind_letter(head.kind);
		end else if (is_digit) begin
			value = {25'd0, head.digits[dsel]};
		end else begin
			value = head.chr;
		end
	end

	assign load = not_empty && (!ov_q || result.ready);
	assign pop  = load && last;

	assign result.valid        = ov_q;
	assign result.decoded_char = char_q;
	assign result.string_done  = done_q;
	assign result.last_of_run  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
				ov_q  <= 1'b1;
			end else if (result.ready) begin
				ov_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= value;
			done_q <= last && head.eos;
			last_q <= last;
		end
	end

endmodule

// ===== rtl/eseq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eseq_checker
// Port-level checks on the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module eseq_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic         in_eos,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [31:0]  out_char,
	input  logic         out_done,
	input  logic         out_last
);

	logic [7:0] pend_q;
	logic       in_eos_acc, out_done_acc;

	assign in_eos_acc   = in_valid && in_ready && in_eos;
	assign out_done_acc = out_valid && out_ready && out_done;

	// strings accepted whose final result has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'd0;
		end else if (in_eos_acc && !out_done_acc) begin
			pend_q <= pend_q + 8'd1;
		end else if (out_done_acc && !in_eos_acc) begin
			pend_q <= pend_q - 8'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(out_done) && $stable(out_last))
		else $error("stalled result changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> out_last)
		else $error("string end not on last result of its item");

	a_done_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> pend_q != 8'd0)
		else $error("string end with no string pending");

	// an edge seen in reset leaves the output empty for the next cycle
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind escape_sequence_decoder eseq_checker u_eseq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text.valid),
	.in_ready  (text.ready),
	.in_eos    (text.end_of_string),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_char  (result.decoded_char),
	.out_done  (result.string_done),
	.out_last  (result.last_of_run)
);
